>>> hw/rtl/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/rsm_pkg.sv
// types and constants shared by the row softmax modules
package rsm_pkg;

    localparam int DIVIDEND_W   = 49;
    localparam int DIVISOR_W    = 23;
    localparam int EXP_W        = 17;
    localparam int SUM_W        = 23;
    localparam int Q48_W        = 49;
    localparam int SERIES_TERMS = 40;
    localparam int UNDERFLOW_K  = 3072;

    localparam logic [Q48_W-1:0] Q48_ONE    = 49'h1_0000_0000_0000;
    localparam logic [Q48_W-1:0] ROUND_HALF = 49'h0_0000_8000_0000;
    localparam logic [15:0]      PROB_MAX   = 16'hFFFF;
    localparam logic [15:0]      SCORE_MIN  = 16'h8000;

    typedef struct packed {
        logic signed [15:0] score;
        logic               end_of_row;
    } score_t;

    typedef struct packed {
        logic [15:0] prob;
        logic [5:0]  position;
        logic        truncated;
        logic        last_result;
    } result_t;

    typedef struct packed {
        logic       start;
        logic [7:0] frac;
        logic [3:0] whole;
    } exp_req_t;

endpackage

>>> hw/rtl/rsm_div.sv
// restoring divider, one quotient bit per cycle
module rsm_div (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic [rsm_pkg::DIVIDEND_W-1:0]  dividend,
    input  logic [rsm_pkg::DIVISOR_W-1:0]   divisor,
    output logic                            done,
    output logic [rsm_pkg::DIVIDEND_W-1:0]  quotient
);

    localparam int CNT_W = $clog2(rsm_pkg::DIVIDEND_W);
    localparam int DW    = rsm_pkg::DIVIDEND_W;
    localparam int VW    = rsm_pkg::DIVISOR_W;

    logic [VW-1:0]    rem_reg, rem_next;
    logic [DW-1:0]    quo_reg, quo_next;
    logic [VW-1:0]    dsr_reg, dsr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [VW:0]      trial;
    logic [VW:0]      diff;
    logic             fits;

    always_comb
    begin
        trial     = {rem_reg, quo_reg[DW-1]};
        diff      = trial - {1'b0, dsr_reg};
        fits      = trial >= {1'b0, dsr_reg};
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = '0;
            quo_next  = dividend;
            dsr_next  = divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? diff[VW-1:0] : trial[VW-1:0];
            quo_next = {quo_reg[DW-2:0], fits};
            cnt_next = cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_W'(DW - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

>>> hw/rtl/rsm_exp.sv
// fixed-point exponential unit: series for the fraction, repeated e^-1 products
module rsm_exp (
    input  logic                          clk,
    input  logic                          rst_n,
    input  rsm_pkg::exp_req_t             req,
    output logic                          done,
    output logic [rsm_pkg::EXP_W-1:0]     value
);

    localparam int QW = rsm_pkg::Q48_W;

    typedef enum logic [5:0] {
        X_IDLE  = 6'b000001,
        X_MUL   = 6'b000010,
        X_DGO   = 6'b000100,
        X_DWAIT = 6'b001000,
        X_QMUL  = 6'b010000,
        X_DONE  = 6'b100000
    } xstate_t;

    xstate_t         state_reg, state_next;
    logic [QW-1:0]   term_reg, term_next;
    logic [QW:0]     pos_reg, pos_next;
    logic [QW:0]     neg_reg, neg_next;
    logic [5:0]      n_reg, n_next;
    logic [8:0]      sr_reg, sr_next;
    logic [7:0]      frac_reg, frac_next;
    logic [3:0]      whole_reg, whole_next;
    logic [QW-1:0]   v_reg, v_next;
    logic [QW-1:0]   e1_reg, e1_next;
    logic            e1_ok_reg, e1_ok_next;
    logic            for_e1_reg, for_e1_next;
    logic [QW-1:0]   prod_reg, prod_next;
    logic [1:0]      qstep_reg, qstep_next;
    logic [50:0]     mid_reg, mid_next;

    logic [57:0]     sprod;
    logic [24:0]     mul_x, mul_y;
    logic [49:0]     qm;
    logic [QW:0]     pos_upd, neg_upd;
    logic [QW:0]     series_diff;
    logic [QW-1:0]   series_res;
    logic [QW-1:0]   rnd;
    logic            div_start;
    logic            div_done;
    logic [rsm_pkg::DIVIDEND_W-1:0] div_quo;

    rsm_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (prod_reg),
        .divisor  (rsm_pkg::DIVISOR_W'(n_reg)),
        .done     (div_done),
        .quotient (div_quo)
    );

    always_comb
    begin
        sprod = term_reg * sr_reg;
        case (qstep_reg)
            2'd0:
            begin
                mul_x = {1'b0, v_reg[23:0]};
                mul_y = {1'b0, e1_reg[23:0]};
            end
            2'd1:
            begin
                mul_x = v_reg[48:24];
                mul_y = {1'b0, e1_reg[23:0]};
            end
            2'd2:
            begin
                mul_x = {1'b0, v_reg[23:0]};
                mul_y = e1_reg[48:24];
            end
            default:
            begin
                mul_x = v_reg[48:24];
                mul_y = e1_reg[48:24];
            end
        endcase
        qm = mul_x * mul_y;

        pos_upd     = n_reg[0] ? pos_reg : pos_reg + {1'b0, div_quo};
        neg_upd     = n_reg[0] ? neg_reg + {1'b0, div_quo} : neg_reg;
        series_diff = pos_upd - neg_upd;
        series_res  = (pos_upd > neg_upd) ? series_diff[QW-1:0] : '0;
        rnd         = v_reg + rsm_pkg::ROUND_HALF;
    end

    always_comb
    begin
        state_next  = state_reg;
        term_next   = term_reg;
        pos_next    = pos_reg;
        neg_next    = neg_reg;
        n_next      = n_reg;
        sr_next     = sr_reg;
        frac_next   = frac_reg;
        whole_next  = whole_reg;
        v_next      = v_reg;
        e1_next     = e1_reg;
        e1_ok_next  = e1_ok_reg;
        for_e1_next = for_e1_reg;
        prod_next   = prod_reg;
        qstep_next  = qstep_reg;
        mid_next    = mid_reg;
        div_start   = 1'b0;
        done        = 1'b0;
        case (state_reg)
            X_IDLE:
            begin
                if (req.start)
                begin
                    frac_next   = req.frac;
                    whole_next  = req.whole;
                    term_next   = rsm_pkg::Q48_ONE;
                    pos_next    = {1'b0, rsm_pkg::Q48_ONE};
                    neg_next    = '0;
                    n_next      = 6'd1;
                    sr_next     = e1_ok_reg ? {1'b0, req.frac} : 9'd256;
                    for_e1_next = !e1_ok_reg;
                    state_next  = X_MUL;
                end
            end
            X_MUL:
            begin
                prod_next  = sprod[56:8];
                state_next = X_DGO;
            end
            X_DGO:
            begin
                div_start  = 1'b1;
                state_next = X_DWAIT;
            end
            X_DWAIT:
            begin
                if (div_done)
                begin
                    term_next = div_quo;
                    pos_next  = pos_upd;
                    neg_next  = neg_upd;
                    if (n_reg == 6'(rsm_pkg::SERIES_TERMS))
                    begin
                        if (for_e1_reg)
                        begin
                            e1_next     = series_res;
                            e1_ok_next  = 1'b1;
                            for_e1_next = 1'b0;
                            term_next   = rsm_pkg::Q48_ONE;
                            pos_next    = {1'b0, rsm_pkg::Q48_ONE};
                            neg_next    = '0;
                            n_next      = 6'd1;
                            sr_next     = {1'b0, frac_reg};
                            state_next  = X_MUL;
                        end
                        else
                        begin
                            v_next     = series_res;
                            qstep_next = 2'd0;
                            state_next = (whole_reg == 4'd0) ? X_DONE : X_QMUL;
                        end
                    end
                    else
                    begin
                        n_next     = n_reg + 6'd1;
                        state_next = X_MUL;
                    end
                end
            end
            X_QMUL:
            begin
                qstep_next = qstep_reg + 2'd1;
                case (qstep_reg)
                    2'd0:    mid_next = 51'(qm >> 24);
                    2'd1:    mid_next = mid_reg + 51'(qm);
                    2'd2:    mid_next = mid_reg + 51'(qm);
                    default:
                    begin
                        v_next     = QW'(qm + 50'(mid_reg >> 24));
                        whole_next = whole_reg - 4'd1;
                        if (whole_reg == 4'd1)
                        begin
                            state_next = X_DONE;
                        end
                    end
                endcase
            end
            X_DONE:
            begin
                done       = 1'b1;
                state_next = X_IDLE;
            end
            default:
            begin
                state_next = X_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= X_IDLE;
            e1_ok_reg  <= 1'b0;
            for_e1_reg <= 1'b0;
            n_reg      <= '0;
            qstep_reg  <= '0;
            whole_reg  <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            e1_ok_reg  <= e1_ok_next;
            for_e1_reg <= for_e1_next;
            n_reg      <= n_next;
            qstep_reg  <= qstep_next;
            whole_reg  <= whole_next;
        end
    end

    always_ff @(posedge clk)
    begin
        term_reg <= term_next;
        pos_reg  <= pos_next;
        neg_reg  <= neg_next;
        sr_reg   <= sr_next;
        frac_reg <= frac_next;
        v_reg    <= v_next;
        e1_reg   <= e1_next;
        prod_reg <= prod_next;
        mid_reg  <= mid_next;
    end

    assign value = rnd[48:32];

endmodule

>>> hw/rtl/row_softmax.sv
// row softmax top level: row memories, pass sequencer and output register
//
// channel   | valid        | ready        | payload
// ----------+--------------+--------------+--------------------------
// scores    | score_valid  | score_ready  | score_item  (score_t)
// results   | result_valid | result_ready | result_item (result_t)
//
// an accepted element is stored if the row has room; closing a row runs an exp pass and a
// normalize pass over the row memories, one element at a time
// exp pass: a 40-term series per element, then one product by e^-1 per whole unit;
// the very first exp after reset also builds the e^-1 constant (another series)
// normalize pass: each result is set by a run of the bit-serial divider
// scores are refused while a row is being processed; a stalled result holds
// reset clears control state only, no memory clearing pass
module row_softmax #(
    parameter int MAX_ROW = 64
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             score_valid,
    output logic             score_ready,
    input  rsm_pkg::score_t  score_item,
    output logic             result_valid,
    input  logic             result_ready,
    output rsm_pkg::result_t result_item
);

    localparam int AW = (MAX_ROW > 1) ? $clog2(MAX_ROW) : 1;
    localparam int CW = $clog2(MAX_ROW + 1);

    typedef enum logic [7:0] {
        T_IN    = 8'b00000001,
        T_ERD   = 8'b00000010,
        T_EK    = 8'b00000100,
        T_EWAIT = 8'b00001000,
        T_NRD   = 8'b00010000,
        T_NGO   = 8'b00100000,
        T_NWAIT = 8'b01000000,
        T_OUT   = 8'b10000000
    } tstate_t;

    tstate_t                      state_reg, state_next;
    logic [CW-1:0]                count_reg, count_next;
    logic signed [15:0]           max_reg, max_next;
    logic [rsm_pkg::SUM_W-1:0]    sum_reg, sum_next;
    logic                         ovf_reg, ovf_next;
    logic [AW-1:0]                idx_reg, idx_next;
    logic                         out_valid_reg, out_valid_next;
    rsm_pkg::result_t             out_reg, out_next;

    logic [15:0]                  score_mem [MAX_ROW];
    logic [rsm_pkg::EXP_W-1:0]    exp_mem   [MAX_ROW];
    logic [15:0]                  score_rd_reg;
    logic [rsm_pkg::EXP_W-1:0]    exp_rd_reg;

    logic                         accept;
    logic                         score_we;
    logic                         exp_we;
    logic [rsm_pkg::EXP_W-1:0]    exp_wd;
    logic                         last_idx;
    logic [16:0]                  kdiff;
    logic                         uflow;
    rsm_pkg::exp_req_t            exp_req;
    logic                         exp_done;
    logic [rsm_pkg::EXP_W-1:0]    exp_value;
    logic                         div_start;
    logic                         div_done;
    logic [rsm_pkg::DIVIDEND_W-1:0] div_quo;
    logic [15:0]                  prob;

    rsm_exp u_exp (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (exp_req),
        .done  (exp_done),
        .value (exp_value)
    );

    rsm_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (rsm_pkg::DIVIDEND_W'({exp_rd_reg, 16'h0000})),
        .divisor  (sum_reg),
        .done     (div_done),
        .quotient (div_quo)
    );

    always_ff @(posedge clk)
    begin
        if (score_we)
        begin
            score_mem[count_reg[AW-1:0]] <= score_item.score;
        end
        score_rd_reg <= score_mem[idx_reg];
    end

    always_ff @(posedge clk)
    begin
        if (exp_we)
        begin
            exp_mem[idx_reg] <= exp_wd;
        end
        exp_rd_reg <= exp_mem[idx_reg];
    end

    always_comb
    begin
        accept   = score_valid && (state_reg == T_IN);
        score_we = accept && (count_reg < CW'(MAX_ROW));
        last_idx = (CW'(idx_reg) + CW'(1)) == count_reg;
        kdiff    = {max_reg[15], max_reg} - {score_rd_reg[15], score_rd_reg};
        uflow    = kdiff >= 17'(rsm_pkg::UNDERFLOW_K);
        if (sum_reg == '0)
        begin
            prob = '0;
        end
        else if (div_quo > rsm_pkg::DIVIDEND_W'(rsm_pkg::PROB_MAX))
        begin
            prob = rsm_pkg::PROB_MAX;
        end
        else
        begin
            prob = div_quo[15:0];
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        max_next       = max_reg;
        sum_next       = sum_reg;
        ovf_next       = ovf_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        exp_we         = 1'b0;
        exp_wd         = exp_value;
        exp_req.start  = 1'b0;
        exp_req.frac   = kdiff[7:0];
        exp_req.whole  = kdiff[11:8];
        div_start      = 1'b0;
        case (state_reg)
            T_IN:
            begin
                if (accept)
                begin
                    if (score_we)
                    begin
                        count_next = count_reg + CW'(1);
                        if (score_item.score > max_reg)
                        begin
                            max_next = score_item.score;
                        end
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                    if (score_item.end_of_row)
                    begin
                        idx_next   = '0;
                        sum_next   = '0;
                        state_next = T_ERD;
                    end
                end
            end
            T_ERD:
            begin
                state_next = T_EK;
            end
            T_EK:
            begin
                if (uflow)
                begin
                    exp_we = 1'b1;
                    exp_wd = '0;
                    if (last_idx)
                    begin
                        idx_next   = '0;
                        state_next = T_NRD;
                    end
                    else
                    begin
                        idx_next   = idx_reg + AW'(1);
                        state_next = T_ERD;
                    end
                end
                else
                begin
                    exp_req.start = 1'b1;
                    state_next    = T_EWAIT;
                end
            end
            T_EWAIT:
            begin
                if (exp_done)
                begin
                    exp_we   = 1'b1;
                    sum_next = sum_reg + rsm_pkg::SUM_W'(exp_value);
                    if (last_idx)
                    begin
                        idx_next   = '0;
                        state_next = T_NRD;
                    end
                    else
                    begin
                        idx_next   = idx_reg + AW'(1);
                        state_next = T_ERD;
                    end
                end
            end
            T_NRD:
            begin
                state_next = T_NGO;
            end
            T_NGO:
            begin
                div_start  = 1'b1;
                state_next = T_NWAIT;
            end
            T_NWAIT:
            begin
                if (div_done)
                begin
                    out_next.prob        = prob;
                    out_next.position    = 6'(idx_reg);
                    out_next.truncated   = ovf_reg;
                    out_next.last_result = last_idx;
                    out_valid_next       = 1'b1;
                    state_next           = T_OUT;
                end
            end
            T_OUT:
            begin
                if (result_ready)
                begin
                    out_valid_next = 1'b0;
                    if (last_idx)
                    begin
                        count_next = '0;
                        max_next   = rsm_pkg::SCORE_MIN;
                        ovf_next   = 1'b0;
                        idx_next   = '0;
                        state_next = T_IN;
                    end
                    else
                    begin
                        idx_next   = idx_reg + AW'(1);
                        state_next = T_NRD;
                    end
                end
            end
            default:
            begin
                state_next = T_IN;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= T_IN;
            count_reg     <= '0;
            max_reg       <= rsm_pkg::SCORE_MIN;
            sum_reg       <= '0;
            ovf_reg       <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            max_reg       <= max_next;
            sum_reg       <= sum_next;
            ovf_reg       <= ovf_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign score_ready  = (state_reg == T_IN);
    assign result_valid = out_valid_reg;
    assign result_item  = out_reg;

endmodule

>>> hw/rtl/rsm_checker.sv
// port checker for the row softmax top level, with its bind
`include "assert_macros.svh"

module rsm_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             score_ready,
    input logic             result_valid,
    input logic             result_ready,
    input rsm_pkg::result_t result_item
);

    logic stall;
    logic mid_xfer;
    logic end_xfer;

    assign stall    = result_valid && !result_ready;
    assign mid_xfer = result_valid && result_ready && !result_item.last_result;
    assign end_xfer = result_valid && result_ready && result_item.last_result;

    `ASSERT_NEXT(a_result_hold, clk, rst_n, stall, result_valid && $stable(result_item), "moved")
    `ASSERT_NOW(a_no_overlap, clk, rst_n, result_valid, !score_ready, "ready with result pending")
    `ASSERT_NEXT(a_mid_row, clk, rst_n, mid_xfer, !score_ready, "ready before row end")
    `ASSERT_NEXT(a_row_end, clk, rst_n, end_xfer, score_ready && !result_valid, "not idle after row")

endmodule

bind row_softmax rsm_checker u_rsm_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .score_ready  (score_ready),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result_item  (result_item)
);

>>> dv/row_softmax_tb.sv
// testbench for row_softmax: directed and random rows checked against an in-bench fixed-point softmax
`timescale 1ns / 1ps

module row_softmax_tb;

    localparam int ROW_CAP    = 64;
    localparam int QUIET_MAX  = 600000;
    localparam int DRAIN_WAIT = 300;
    localparam logic [63:0] ONE_Q48 = 64'h1_0000_0000_0000;

    logic             clk;
    logic             rst_n;
    logic             score_valid;
    logic             score_ready;
    rsm_pkg::score_t  score_item;
    logic             result_valid;
    logic             result_ready = 1'b0;
    rsm_pkg::result_t result_item;

    int send_idle_pct;
    int recv_stall_pct;
    int quiet_cycles = 0;
    int items_sent;

    row_softmax #(.MAX_ROW(ROW_CAP)) dut (
        .clk(clk), .rst_n(rst_n),
        .score_valid(score_valid), .score_ready(score_ready), .score_item(score_item),
        .result_valid(result_valid), .result_ready(result_ready), .result_item(result_item)
    );

    class softmax_scoreboard;
        logic signed [15:0] row_scores[$];
        logic signed [15:0] row_max;
        bit                 row_dropped;
        rsm_pkg::result_t   expected_probs[$];
        int                 errors;

        function new();
            row_max = rsm_pkg::SCORE_MIN;
            row_dropped = 0;
            errors = 0;
        endfunction

        function automatic logic [63:0] exp_neg_q48(int unsigned r);
            logic [63:0] term, pos, neg;
            term = ONE_Q48;
            pos = ONE_Q48;
            neg = 0;
            for (int n = 1; n <= rsm_pkg::SERIES_TERMS; n++) begin
                term = (term * 64'(r)) / (64'(256) * 64'(n));
                if (n % 2 == 1) neg += term;
                else pos += term;
            end
            return (pos > neg) ? pos - neg : 64'd0;
        endfunction

        function automatic logic [63:0] q48_product(logic [63:0] a, logic [63:0] b);
            logic [63:0] ah, al, bh, bl, mid;
            ah = a >> 24;
            al = a & 64'hFF_FFFF;
            bh = b >> 24;
            bl = b & 64'hFF_FFFF;
            mid = ah * bl + al * bh + ((al * bl) >> 24);
            return ah * bh + (mid >> 24);
        endfunction

        function automatic logic [16:0] exp_q16(int unsigned k);
            logic [63:0] v, e1;
            if (k >= rsm_pkg::UNDERFLOW_K) return 17'd0;
            v = exp_neg_q48(k % 256);
            e1 = exp_neg_q48(256);
            for (int i = 0; i < k / 256; i++) v = q48_product(v, e1);
            return 17'((v + (64'd1 << 31)) >> 32);
        endfunction

        function void note_score(rsm_pkg::score_t x);
            logic [16:0]      exps[$];
            logic [22:0]      total;
            logic [63:0]      p;
            rsm_pkg::result_t r;
            int               n;
            if (row_scores.size() < ROW_CAP) begin
                row_scores.push_back(x.score);
                if (x.score > row_max) row_max = x.score;
            end else begin
                row_dropped = 1;
            end
            if (!x.end_of_row) return;
            total = 0;
            n = row_scores.size();
            for (int i = 0; i < n; i++) begin
                exps.push_back(exp_q16(int'(row_max) - int'(row_scores[i])));
                total = total + 23'(exps[i]);
            end
            for (int i = 0; i < n; i++) begin
                p = (total == 0) ? 64'd0 : (64'(exps[i]) << 16) / 64'(total);
                r.prob = (p > 64'd65535) ? rsm_pkg::PROB_MAX : p[15:0];
                r.position = 6'(i);
                r.truncated = row_dropped;
                r.last_result = (i + 1 == n);
                expected_probs.push_back(r);
            end
            row_scores.delete();
            row_max = rsm_pkg::SCORE_MIN;
            row_dropped = 0;
        endfunction

        task report(string what);
            $display("mismatch at %0t: %s", $time, what);
            errors++;
        endtask

        task check_result(rsm_pkg::result_t got);
            rsm_pkg::result_t want;
            if (expected_probs.size() == 0) begin
                report($sformatf("unexpected result %p", got));
                return;
            end
            want = expected_probs.pop_front();
            if (got.prob !== want.prob)
                report($sformatf("prob %0d, expected %0d", got.prob, want.prob));
            if (got.position !== want.position)
                report($sformatf("position %0d, expected %0d", got.position, want.position));
            if (got.truncated !== want.truncated)
                report($sformatf("truncated %b, expected %b", got.truncated, want.truncated));
            if (got.last_result !== want.last_result)
                report($sformatf("last_result %b, expected %b",
                                 got.last_result, want.last_result));
        endtask

        function int pending();
            return expected_probs.size();
        endfunction
    endclass

    softmax_scoreboard sb;

    initial begin
        clk = 0;
        forever #1 clk = ~clk;
    end

    task send_score(logic signed [15:0] s, logic last);
        rsm_pkg::score_t x;
        x.score = s;
        x.end_of_row = last;
        while ($urandom_range(99) < send_idle_pct) begin
            score_valid <= 0;
            @(posedge clk);
        end
        score_valid <= 1;
        score_item <= x;
        do @(posedge clk); while (!score_ready);
        sb.note_score(x);
        items_sent++;
    endtask

    // narrow rows keep most exps above underflow
    task send_row(int len, bit narrow);
        int base;
        int v;
        base = $urandom_range(65535) - 32768;
        for (int i = 0; i < len; i++) begin
            if (narrow) begin
                v = base + $urandom_range(3600) - 1800;
                if (v > 32767) v = 32767;
                if (v < -32768) v = -32768;
            end else begin
                v = $urandom_range(65535) - 32768;
            end
            send_score(16'(v), i == len - 1);
        end
    endtask

    task wait_drained();
        score_valid <= 0;
        while (sb.pending() != 0) @(posedge clk);
    endtask

    task random_phase(int count);
        int stop_at;
        stop_at = items_sent + count;
        while (items_sent < stop_at)
            send_row($urandom_range(1, 8), $urandom_range(3) != 0);
    endtask

    always @(posedge clk) begin
        if (rst_n && result_valid && result_ready) sb.check_result(result_item);
        result_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge clk) begin
        if ((score_valid && score_ready) || (result_valid && result_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_MAX) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin
        sb = new();
        rst_n = 0;
        score_valid = 0;
        score_item = '0;
        items_sent = 0;
        send_idle_pct = 36;
        recv_stall_pct = 54;
        repeat (7) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        send_score(16'sh7FFF, 1);
        send_score(-16'sh8000, 1);
        send_score(-16'sh8000, 0);
        send_score(16'sh7FFF, 1);
        send_score(16'sd0, 0);
        send_score(-16'sd3071, 0);
        send_score(-16'sd3072, 0);
        send_score(-16'sd3073, 0);
        send_score(-16'sd256, 0);
        send_score(-16'sd2816, 1);
        send_score(16'sd100, 0);
        send_score(16'sd100, 0);
        send_score(16'sd100, 1);
        send_score(-16'sd1, 0);
        send_score(-16'sd129, 0);
        send_score(-16'sd2, 1);
        wait_drained();

        random_phase(55);
        wait_drained();
        send_idle_pct = 54;
        recv_stall_pct = 36;
        send_row(ROW_CAP, 1);
        random_phase(45);
        wait_drained();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        send_row(ROW_CAP + 2, 1);
        random_phase(30);
        wait_drained();

        repeat (DRAIN_WAIT) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule

>>> files.f
+incdir+hw/rtl
hw/rtl/rsm_pkg.sv
hw/rtl/rsm_div.sv
hw/rtl/rsm_exp.sv
hw/rtl/row_softmax.sv
hw/rtl/rsm_checker.sv
dv/row_softmax_tb.sv
